@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/tfdm_pkg.sv @@
// ----------------------------------------------------------------------------
// tfdm_pkg
// Shared constants and types for the three-frame difference mask.
// ----------------------------------------------------------------------------
package tfdm_pkg;

    localparam int MAX_PIXELS = 131072;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int CNT_W      = ADDR_W + 1;

    localparam logic [7:0] THRESHOLD_RESET = 8'd8;

    localparam logic [12:0] GRAY_WR    = 13'd4899;
    localparam logic [13:0] GRAY_WG    = 14'd9617;
    localparam logic [10:0] GRAY_WB    = 11'd1868;
    localparam logic [13:0] GRAY_ROUND = 14'd8192;
    localparam int          GRAY_SHIFT = 14;
    localparam int          ACC_W      = 22;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef enum logic [1:0] {
        PHASE_FIRST,
        PHASE_SECOND,
        PHASE_RUN
    } phase_t;

    typedef struct packed {
        logic       mark;
        logic [7:0] gray;
    } entry_t;

    typedef struct packed {
        addr_t addr;
        logic  ovf;
        logic  eof;
        logic  mask_valid;
    } pix_ctl_t;

    typedef struct packed {
        logic   en;
        addr_t  addr;
        entry_t data;
    } store_wr_t;

    typedef struct packed {
        logic motion;
        logic mask_valid;
        logic frame_done;
        logic overflow;
    } result_t;

endpackage

@@ hw/rtl/tfdm_frame_store.sv @@
// ----------------------------------------------------------------------------
// tfdm_frame_store
// Previous gray and change mark per pixel; one read and one write port,
// registered read data.
// ----------------------------------------------------------------------------
module tfdm_frame_store (
    input  logic               clk,
    input  logic               rd_en,
    input  tfdm_pkg::addr_t    rd_addr,
    output tfdm_pkg::entry_t   rd_data,
    input  tfdm_pkg::store_wr_t wr
);
    import tfdm_pkg::*;

    entry_t mem [MAX_PIXELS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/tfdm_diff_stage.sv @@
// ----------------------------------------------------------------------------
// tfdm_diff_stage
// Gray conversion, compare stage with store read data, write-back and
// forwarding of a write-back to the same pixel.
// ----------------------------------------------------------------------------
module tfdm_diff_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                adv,
    input  logic [7:0]          blue,
    input  logic [7:0]          green,
    input  logic [7:0]          red,
    input  tfdm_pkg::pix_ctl_t  ctl_in,
    input  tfdm_pkg::entry_t    rd_data,
    input  logic [7:0]          threshold,
    output logic                valid,
    output tfdm_pkg::store_wr_t wr,
    output tfdm_pkg::result_t   result
);
    import tfdm_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    pix_ctl_t         ctl_reg;
    logic [7:0]       gray_reg;
    logic             fwd_hit_reg;
    entry_t           fwd_data_reg;
    logic [ACC_W-1:0] acc;
    entry_t           prev;
    logic [7:0]       diff;
    logic             mark;

    assign acc = ACC_W'(red) * ACC_W'(GRAY_WR) + ACC_W'(green) * ACC_W'(GRAY_WG)
               + ACC_W'(blue) * ACC_W'(GRAY_WB) + ACC_W'(GRAY_ROUND);

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (adv)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg      <= ctl_in;
            gray_reg     <= acc[GRAY_SHIFT +: 8];
            fwd_hit_reg  <= wr.en && !ctl_in.ovf && (wr.addr == ctl_in.addr);
            fwd_data_reg <= wr.data;
        end
    end

    assign prev = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign diff = (gray_reg >= prev.gray) ? (gray_reg - prev.gray) : (prev.gray - gray_reg);
    assign mark = diff > threshold;

    assign wr.en        = adv && valid_reg && !ctl_reg.ovf;
    assign wr.addr      = ctl_reg.addr;
    assign wr.data.mark = mark;
    assign wr.data.gray = gray_reg;

    assign result.motion     = ctl_reg.mask_valid && !ctl_reg.ovf && mark && prev.mark;
    assign result.mask_valid = ctl_reg.mask_valid;
    assign result.frame_done = ctl_reg.eof;
    assign result.overflow   = ctl_reg.ovf;

    assign valid = valid_reg;

endmodule

@@ hw/rtl/three_frame_difference_mask.sv @@
// ----------------------------------------------------------------------------
// three_frame_difference_mask
// Gray conversion of a BGR pixel stream and a motion mask from two
// consecutive frame differences, using a per-pixel frame store.
// ----------------------------------------------------------------------------
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: blue, green, red; tlast: end_of_frame
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: motion; tuser: mask_valid, overflow;
//                                              tlast: frame_done
// cfg       in   cfg_valid/cfg_ready           cfg_data: diff_threshold
//
// One pixel per cycle sustained while the output is not stalled; the store can do one read and one write per cycle.
// A pixel's store read and gray value are registered in the compare stage, then its result in the output register.
// Reset clears counters and phase and sets the threshold to 8; the frame store is not cleared.
// A stalled output holds the result; one more pixel may enter the compare stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_frame_difference_mask (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // blue[7:0], green[15:8], red[23:16]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // motion[0], zero fill
    output logic [1:0]  m_axis_tuser,   // mask_valid[0], overflow[1]
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import tfdm_pkg::*;

    count_t    pixel_index_reg;
    count_t    pixel_index_next;
    phase_t    phase_reg;
    phase_t    phase_next;
    logic [7:0] threshold_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    result_t   out_reg;
    logic      s_fire;
    logic      s1_valid;
    logic      s1_adv;
    logic      ovf;
    pix_ctl_t  ctl;
    entry_t    rd_data;
    store_wr_t wr;
    result_t   s1_result;

    assign ovf            = pixel_index_reg >= count_t'(MAX_PIXELS);
    assign ctl.addr       = pixel_index_reg[ADDR_W-1:0];
    assign ctl.ovf        = ovf;
    assign ctl.eof        = s_axis_tlast;
    assign ctl.mask_valid = phase_reg == PHASE_RUN;

    assign s1_adv        = s1_valid && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid || s1_adv;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        pixel_index_next = pixel_index_reg;
        if (s_fire)
        begin
            if (s_axis_tlast)
            begin
                pixel_index_next = '0;
            end
            else if (ovf)
            begin
                pixel_index_next = count_t'(MAX_PIXELS);
            end
            else
            begin
                pixel_index_next = pixel_index_reg + count_t'(1);
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (s_fire && s_axis_tlast)
        begin
            case (phase_reg)
                PHASE_FIRST:  phase_next = PHASE_SECOND;
                PHASE_SECOND: phase_next = PHASE_RUN;
                default:      phase_next = PHASE_RUN;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_index_reg <= '0;
            phase_reg       <= PHASE_FIRST;
            threshold_reg   <= THRESHOLD_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pixel_index_reg <= pixel_index_next;
            phase_reg       <= phase_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid)
            begin
                threshold_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_reg <= s1_result;
        end
    end

    tfdm_frame_store u_store (
        .clk     (clk),
        .rd_en   (s_fire && !ovf),
        .rd_addr (ctl.addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    tfdm_diff_stage u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s_fire),
        .adv       (s1_adv),
        .blue      (s_axis_tdata[7:0]),
        .green     (s_axis_tdata[15:8]),
        .red       (s_axis_tdata[23:16]),
        .ctl_in    (ctl),
        .rd_data   (rd_data),
        .threshold (threshold_reg),
        .valid     (s1_valid),
        .wr        (wr),
        .result    (s1_result)
    );

    assign cfg_ready       = 1'b1;
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {7'b0, out_reg.motion};
    assign m_axis_tuser    = {out_reg.overflow, out_reg.mask_valid};
    assign m_axis_tlast    = out_reg.frame_done;

    `ASSERT_SAME(a_motion_needs_valid, clk, rst_n, out_valid_reg && out_reg.motion, out_reg.mask_valid && !out_reg.overflow)
    `ASSERT_NEXT(a_eof_restarts_index, clk, rst_n, s_fire && s_axis_tlast, pixel_index_reg == '0)
    `ASSERT_NEXT(a_stalled_stage_holds, clk, rst_n, s1_valid && !s1_adv, s1_valid)
    `ASSERT_SAME(a_index_saturates, clk, rst_n, 1'b1, pixel_index_reg <= count_t'(MAX_PIXELS))

endmodule

@@ bench/three_frame_difference_mask_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_frame_difference_mask_tb
// Feeds BGR pixel frames into the motion mask block and checks every result
// against a cycle-free model of the gray conversion, the frame stores and the
// frame phase. Three directed frames that cover every random position come
// first, then short random frames under several thresholds with random stalls
// on both sides.
// ----------------------------------------------------------------------------
module three_frame_difference_mask_tb;
    import tfdm_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int QUEUE_DEPTH = 32;
    localparam int RAND_SPAN   = 64;

    typedef enum int {
        GAPS_NONE,
        GAPS_RANDOM,
        GAPS_RARE
    } gap_mode_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       eof;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // blue[7:0], green[15:8], red[23:16]
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // motion[0], zero fill
    logic [1:0]  m_axis_tuser;          // mask_valid[0], overflow[1]
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    // model state
    logic [7:0]  gray_store [MAX_PIXELS];
    bit          mark_store [MAX_PIXELS];
    int          pixel_pos;
    phase_t      frame_phase;
    logic [7:0]  threshold;

    pixel_t      pending_pixels[$];
    result_t     expected_results[$];
    pixel_t      next_px;
    result_t     want_res;
    logic [7:0]  gray_level [RAND_SPAN];
    gap_mode_t   tx_mode;
    gap_mode_t   rx_mode;
    int          tx_gap;
    int          rx_gap;
    int          pushed_count = 0;
    int          accepted_count = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    three_frame_difference_mask u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int draw_gap(gap_mode_t mode);
        case (mode)
            GAPS_RANDOM: return $urandom_range(0, 12);
            GAPS_RARE:   return ($urandom_range(0, 99) == 0) ? $urandom_range(1, 12) : 0;
            default:     return 0;
        endcase
    endfunction

    function automatic result_t predict_mask(pixel_t px);
        logic [21:0] acc;
        logic [7:0]  gray;
        logic [7:0]  diff;
        logic        mark;
        result_t     res;
        acc = 22'(px.red) * 22'(GRAY_WR) + 22'(px.green) * 22'(GRAY_WG)
            + 22'(px.blue) * 22'(GRAY_WB) + 22'(GRAY_ROUND);
        gray = acc[21:14];
        res = '0;
        res.mask_valid = (frame_phase == PHASE_RUN);
        res.frame_done = px.eof;
        if (pixel_pos < MAX_PIXELS)
        begin
            diff = (gray >= gray_store[pixel_pos]) ? gray - gray_store[pixel_pos]
                                                   : gray_store[pixel_pos] - gray;
            mark = (diff > threshold);
            if (frame_phase == PHASE_RUN)
                res.motion = mark & mark_store[pixel_pos];
            if (frame_phase != PHASE_FIRST)
                mark_store[pixel_pos] = mark;
            gray_store[pixel_pos] = gray;
            pixel_pos++;
        end
        else
            res.overflow = 1'b1;
        if (px.eof)
        begin
            pixel_pos = 0;
            if (frame_phase == PHASE_FIRST)
                frame_phase = PHASE_SECOND;
            else
                frame_phase = PHASE_RUN;
        end
        return res;
    endfunction

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(predict_mask(pixel_t'({s_axis_tdata, s_axis_tlast})));
                accepted_count++;
                tx_gap = draw_gap(tx_mode);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_pixels.size() > 0)
                begin
                    next_px = pending_pixels.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {next_px.red, next_px.green, next_px.blue};
                    s_axis_tlast  <= next_px.eof;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual tdata=%0h tuser=%b tlast=%b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    want_res = expected_results.pop_front();
                    check_field("motion", {7'b0, want_res.motion}, m_axis_tdata);
                    check_field("mask_valid", {7'b0, want_res.mask_valid},
                                {7'b0, m_axis_tuser[0]});
                    check_field("overflow", {7'b0, want_res.overflow},
                                {7'b0, m_axis_tuser[1]});
                    check_field("frame_done", {7'b0, want_res.frame_done},
                                {7'b0, m_axis_tlast});
                end
                rx_gap = draw_gap(rx_mode);
            end
            if (rx_gap > 0)
            begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic push_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic eof);
        while (pending_pixels.size() >= QUEUE_DEPTH)
            @(posedge clk);
        pending_pixels.push_back(pixel_t'({red, green, blue, eof}));
        pushed_count++;
    endtask

    task automatic push_gray(input logic [7:0] level, input logic eof);
        push_pixel(level, level, level, eof);
    endtask

    task automatic fill_frame(input int first, input int total);
        for (int i = first; i < total; i++)
            push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), i == total - 1);
    endtask

    // mostly gray pixels near the last level at each position, so the
    // difference lands around the threshold
    task automatic random_frame(input int len);
        int v;
        int span;
        int kind;
        span = int'(threshold) + 3;
        for (int pos = 0; pos < len; pos++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 3)
                push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), pos == len - 1);
            else
            begin
                if (kind == 9)
                    v = $urandom_range(0, 255);
                else
                    v = int'(gray_level[pos]) + int'($urandom_range(0, 2 * span)) - span;
                if (v < 0)
                    v = 0;
                else if (v > 255)
                    v = 255;
                gray_level[pos] = v[7:0];
                push_gray(v[7:0], pos == len - 1);
            end
        end
    endtask

    task automatic wait_idle();
        while (accepted_count != pushed_count || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        threshold = value;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int seg;
        int count;
        int len;
        logic [7:0] next_thr;
        pixel_pos   = 0;
        frame_phase = PHASE_FIRST;
        threshold   = THRESHOLD_RESET;
        tx_mode     = GAPS_RARE;
        rx_mode     = GAPS_RARE;
        for (int p = 0; p < RAND_SPAN; p++)
            gray_level[p] = 8'($urandom_range(0, 255));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // frame 1: gray extremes and primaries
        push_gray(8'd0, 1'b0);
        push_gray(8'd255, 1'b0);
        push_gray(8'd100, 1'b0);
        push_gray(8'd100, 1'b0);
        push_gray(8'd100, 1'b0);
        push_gray(8'd100, 1'b0);
        push_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        fill_frame(9, RAND_SPAN);

        // frame 2: zero and full difference, threshold edges from both sides
        push_gray(8'd0, 1'b0);
        push_gray(8'd0, 1'b0);
        push_gray(8'd108, 1'b0);
        push_gray(8'd109, 1'b0);
        push_gray(8'd91, 1'b0);
        push_gray(8'd92, 1'b0);
        fill_frame(6, RAND_SPAN);

        // frame 3: first valid mask, motion both set and clear
        push_gray(8'd255, 1'b0);
        push_gray(8'd0, 1'b0);
        push_gray(8'd100, 1'b0);
        push_gray(8'd0, 1'b0);
        push_gray(8'd91, 1'b0);
        push_gray(8'd0, 1'b0);
        fill_frame(6, RAND_SPAN);

        for (seg = 0; seg < 10; seg++)
        begin
            case (seg)
                0:       next_thr = 8'd255;
                1:       next_thr = 8'd0;
                default: next_thr = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                                 : 8'($urandom_range(0, 40));
            endcase
            write_threshold(next_thr);
            tx_mode = (seg % 3 == 2) ? GAPS_NONE : GAPS_RANDOM;
            rx_mode = (seg % 4 == 3) ? GAPS_NONE : GAPS_RANDOM;
            count = 0;
            while (count < 90)
            begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, RAND_SPAN);
                random_frame(len);
                count += len;
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
